### hdl/fss_pkg.sv
// fss_pkg: shared widths, register indexes, reset values and types
// for the failover server selector; no dependencies
package fss_pkg;

  localparam int MAX_SERVERS = 16;
  localparam int THR_W       = 8;
  localparam int CNT_VAL_W   = 8;
  localparam int TIME_W      = 32;
  localparam int MASK_W      = 16;
  localparam int IDX_OUT_W   = 4;
  localparam int RND_W       = 16;
  localparam int STEP_W      = $clog2(RND_W);
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  // opcodes and server kinds
  localparam logic OP_FAIL      = 1'b1;
  localparam logic KIND_SCRIPTS = 1'b1;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_REST_THR   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_REST_TIME  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_RETRY_TIME = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_TYPE0_MASK = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_TYPE1_MASK = 3'd4;

  // configuration reset values
  localparam logic [THR_W-1:0]  RST_REST_THR   = 8'd3;
  localparam logic [TIME_W-1:0] RST_REST_TIME  = 32'd600;
  localparam logic [TIME_W-1:0] RST_RETRY_TIME = 32'd30;
  localparam logic [MASK_W-1:0] RST_TYPE_MASK  = 16'h0001;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] server_index;
    logic                 index_valid;
    logic                 entered_rest;
    logic [MASK_W-1:0]    released_mask;
    logic                 all_cleared;
    logic                 none_supported;
  } fss_res_t;

  typedef struct packed {
    logic             start;
    logic [RND_W-1:0] dividend;
  } fss_mod_req_t;

endpackage

### hdl/fss_in_if.sv
// fss_in_if: request channel of the failover server selector
// depends on fss_pkg
interface fss_in_if;
  import fss_pkg::*;

  logic              valid;
  logic              ready;
  logic              opcode;
  logic              server_kind;
  logic [TIME_W-1:0] now_seconds;
  logic [RND_W-1:0]  random_value;

  modport source (output valid, output opcode, output server_kind,
                  output now_seconds, output random_value, input ready);
  modport sink   (input valid, input opcode, input server_kind,
                  input now_seconds, input random_value, output ready);
endinterface

### hdl/fss_out_if.sv
// fss_out_if: result channel of the failover server selector
// depends on fss_pkg
interface fss_out_if;
  import fss_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [IDX_OUT_W-1:0] server_index;
  logic                 index_valid;
  logic                 entered_rest;
  logic [MASK_W-1:0]    released_mask;
  logic                 all_cleared;
  logic                 none_supported;

  modport source (output valid, output server_index, output index_valid,
                  output entered_rest, output released_mask, output all_cleared,
                  output none_supported, input ready);
  modport sink   (input valid, input server_index, input index_valid,
                  input entered_rest, input released_mask, input all_cleared,
                  input none_supported, output ready);
endinterface

### hdl/failover_server_selector.sv
// failover_server_selector: top level, per-server failure tracking and pick
// depends on fss_pkg, fss_in_if, fss_out_if, fss_mod
//
// usage
//   in_if carries one item: opcode (select or report failure of the last
//   pick), server_kind, now_seconds and random_value. out_if returns exactly
//   one result item per request. cfg_we/cfg_addr/cfg_wdata write the five
//   settings registers (threshold, rest time, retry time, two support masks)
//   and the user must write them only while the block is idle (not enforced)
// steps from accept to out_if.valid
//   failure report: read of the charged entry, update, output load;
//   only the output load when nothing has been picked yet
//   select: scan of the N = min(NUM_SERVERS, 16) entries through the
//   single add/compare unit, decision on the pool, the remainder unit
//   (one random bit per cycle, then done), a walk over the pool bits and
//   the output load; only the scan, the decision and the output load
//   when no server supports the type
//   one item is worked on at a time; in_if.ready is high only when idle,
//   which it is again on the cycle the result appears
// reset
//   synchronous, active low: settings return to their defaults, all
//   per-server valid bits drop (an invalid entry reads as count 0, time 0),
//   the last pick is forgotten and out_if.valid drops
// back pressure
//   the result sits in an output register; a new item is accepted while it
//   waits, and a finished item holds in the output state until out_if frees
module failover_server_selector #(
  parameter int NUM_SERVERS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  fss_in_if.sink                            in_if,
  fss_out_if.source                         out_if,
  input  logic                              cfg_we,
  input  logic [fss_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [fss_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import fss_pkg::*;

  // servers at index 16 and up have no support bit and never get touched
  localparam int NUM_ACT  = (NUM_SERVERS < MAX_SERVERS) ? NUM_SERVERS : MAX_SERVERS;
  localparam int IDX_W    = (NUM_ACT > 1) ? $clog2(NUM_ACT) : 1;
  localparam int CNT_W    = $clog2(NUM_ACT + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ACT - 1);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_FRD    = 8'b0000_0010,
    ST_FWR    = 8'b0000_0100,
    ST_SCAN   = 8'b0000_1000,
    ST_DECIDE = 8'b0001_0000,
    ST_MOD    = 8'b0010_0000,
    ST_PICK   = 8'b0100_0000,
    ST_OUT    = 8'b1000_0000
  } state_t;

  state_t state_r;

  // settings registers
  logic [THR_W-1:0]  thr_r;
  logic [TIME_W-1:0] rest_time_r;
  logic [TIME_W-1:0] retry_time_r;
  logic [MASK_W-1:0] mask0_r;
  logic [MASK_W-1:0] mask1_r;

  // per-server store, valid bits cleared by reset
  logic [CNT_VAL_W-1:0] cnt_mem [NUM_ACT];
  logic [TIME_W-1:0]    time_mem [NUM_ACT];
  logic [NUM_ACT-1:0]   vld_r;
  logic [CNT_VAL_W-1:0] cnt_rd_r;
  logic [TIME_W-1:0]    time_rd_r;
  logic                 ent_vld_r;

  // item and scan state
  logic [TIME_W-1:0]  now_r;
  logic [RND_W-1:0]   rnd_r;
  logic [NUM_ACT-1:0] sup_mask_r;
  logic [NUM_ACT-1:0] elig_r;
  logic [NUM_ACT-1:0] rel_r;
  logic [NUM_ACT-1:0] pool_r;
  logic [CNT_W-1:0]   n_sup_r;
  logic [CNT_W-1:0]   n_elig_r;
  logic [IDX_W-1:0]   scan_idx_r;
  logic [IDX_W-1:0]   eval_idx_r;
  logic               issue_on_r;
  logic               eval_vld_r;
  logic [IDX_W-1:0]   pick_idx_r;
  logic [CNT_W-1:0]   seen_r;
  logic [CNT_W-1:0]   tgt_r;
  logic [IDX_W-1:0]   last_pick_r;
  logic               last_pick_valid_r;
  fss_res_t           res_r;
  fss_res_t           out_r;
  logic               out_valid_r;

  // combinational
  logic [MASK_W-1:0]    sel_mask;
  logic [IDX_W-1:0]     rd_addr;
  logic [IDX_W-1:0]     wr_addr;
  logic                 cnt_we;
  logic                 time_we;
  logic [CNT_VAL_W-1:0] cnt_wdata;
  logic [CNT_VAL_W-1:0] cnt_eff;
  logic [TIME_W-1:0]    time_eff;
  logic                 resting;
  logic [TIME_W-1:0]    add_op;
  logic [TIME_W:0]      time_sum;
  logic                 passed;
  logic [CNT_VAL_W-1:0] cnt_inc;
  logic                 sup_bit;
  logic                 eval_elig;
  logic                 eval_rel;
  logic                 use_sup;
  logic                 out_free;
  logic                 pick_hit;
  logic [IDX_OUT_W-1:0] pick_ext;
  logic [IDX_OUT_W-1:0] last_ext;
  logic [MASK_W-1:0]    rel_ext;
  fss_mod_req_t         mod_req;
  logic [CNT_W-1:0]     mod_dsr;
  logic                 mod_done;
  logic [CNT_W-1:0]     mod_rem;

  // settings write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r        <= RST_REST_THR;
      rest_time_r  <= RST_REST_TIME;
      retry_time_r <= RST_RETRY_TIME;
      mask0_r      <= RST_TYPE_MASK;
      mask1_r      <= RST_TYPE_MASK;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_REST_THR:   thr_r        <= cfg_wdata[THR_W-1:0];
        REG_REST_TIME:  rest_time_r  <= cfg_wdata[TIME_W-1:0];
        REG_RETRY_TIME: retry_time_r <= cfg_wdata[TIME_W-1:0];
        REG_TYPE0_MASK: mask0_r      <= cfg_wdata[MASK_W-1:0];
        REG_TYPE1_MASK: mask1_r      <= cfg_wdata[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // shared add/compare unit: one entry evaluated per cycle
  always_comb begin
    sel_mask  = (in_if.server_kind == KIND_SCRIPTS) ? mask1_r : mask0_r;
    cnt_eff   = ent_vld_r ? cnt_rd_r : '0;
    time_eff  = ent_vld_r ? time_rd_r : '0;
    resting   = (cnt_eff >= thr_r);
    add_op    = resting ? rest_time_r : retry_time_r;
    // 33-bit sum, no wrap
    time_sum  = {1'b0, time_eff} + {1'b0, add_op};
    passed    = (time_sum < {1'b0, now_r});
    cnt_inc   = (cnt_eff == '1) ? cnt_eff : cnt_eff + 1'b1;
    sup_bit   = sup_mask_r[eval_idx_r];
    eval_elig = eval_vld_r && sup_bit && passed;
    eval_rel  = eval_elig && resting;
  end

  // store ports: failure update or release of a resting server
  always_comb begin
    rd_addr   = (state_r == ST_FRD) ? last_pick_r : scan_idx_r;
    time_we   = (state_r == ST_FWR);
    // an invalid entry already reads as count zero
    cnt_we    = time_we || (eval_rel && ent_vld_r);
    wr_addr   = time_we ? last_pick_r : eval_idx_r;
    cnt_wdata = time_we ? cnt_inc : '0;
  end

  always_ff @(posedge clk) begin
    cnt_rd_r  <= cnt_mem[rd_addr];
    time_rd_r <= time_mem[rd_addr];
    ent_vld_r <= vld_r[rd_addr];
    if (cnt_we) begin
      cnt_mem[wr_addr] <= cnt_wdata;
    end
    if (time_we) begin
      time_mem[wr_addr] <= now_r;
    end
  end

  // pool choice, remainder request, index widening
  always_comb begin
    use_sup          = (n_elig_r == '0);
    mod_req.start    = (state_r == ST_DECIDE) && (n_sup_r != '0);
    mod_req.dividend = rnd_r;
    mod_dsr          = use_sup ? n_sup_r : n_elig_r;
    out_free         = !out_valid_r || out_if.ready;
    pick_hit         = pool_r[pick_idx_r] && (seen_r == tgt_r);
    pick_ext         = '0;
    pick_ext[IDX_W-1:0] = pick_idx_r;
    last_ext         = '0;
    last_ext[IDX_W-1:0] = last_pick_r;
    rel_ext          = '0;
    rel_ext[NUM_ACT-1:0] = rel_r;
  end

  fss_mod #(
    .DIV_W (CNT_W)
  ) u_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mod_req),
    .divisor (mod_dsr),
    .done    (mod_done),
    .rem     (mod_rem)
  );

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= ST_IDLE;
      vld_r             <= '0;
      issue_on_r        <= 1'b0;
      eval_vld_r        <= 1'b0;
      last_pick_r       <= '0;
      last_pick_valid_r <= 1'b0;
      out_valid_r       <= 1'b0;
    end else begin
      eval_vld_r <= (state_r == ST_SCAN) && issue_on_r;
      // a new result loads in the cycle the old one leaves
      if ((state_r == ST_OUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_if.valid) begin
            if (in_if.opcode == OP_FAIL) begin
              // nothing picked yet: all-zero result
              state_r <= last_pick_valid_r ? ST_FRD : ST_OUT;
            end else begin
              state_r    <= ST_SCAN;
              issue_on_r <= 1'b1;
            end
          end
        end
        ST_FRD: begin
          state_r <= ST_FWR;
        end
        ST_FWR: begin
          vld_r[last_pick_r] <= 1'b1;
          state_r            <= ST_OUT;
        end
        ST_SCAN: begin
          if (issue_on_r && (scan_idx_r == LAST_IDX)) begin
            issue_on_r <= 1'b0;
          end
          if (eval_vld_r && (eval_idx_r == LAST_IDX)) begin
            state_r <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (n_sup_r == '0) begin
            state_r <= ST_OUT;
          end else begin
            // no eligible server: every supporting server back to zero
            if (use_sup) begin
              vld_r <= vld_r & ~sup_mask_r;
            end
            state_r <= ST_MOD;
          end
        end
        ST_MOD: begin
          if (mod_done) begin
            state_r <= ST_PICK;
          end
        end
        ST_PICK: begin
          if (pick_hit) begin
            last_pick_r       <= pick_idx_r;
            last_pick_valid_r <= 1'b1;
            state_r           <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_if.valid) begin
          now_r      <= in_if.now_seconds;
          rnd_r      <= in_if.random_value;
          sup_mask_r <= sel_mask[NUM_ACT-1:0];
          res_r      <= '0;
          scan_idx_r <= '0;
          elig_r     <= '0;
          rel_r      <= '0;
          n_sup_r    <= '0;
          n_elig_r   <= '0;
        end
      end
      ST_FRD: ;
      ST_FWR: begin
        res_r.server_index <= last_ext;
        res_r.index_valid  <= 1'b1;
        res_r.entered_rest <= (cnt_inc >= thr_r);
      end
      ST_SCAN: begin
        eval_idx_r <= scan_idx_r;
        if (issue_on_r && (scan_idx_r != LAST_IDX)) begin
          scan_idx_r <= scan_idx_r + 1'b1;
        end
        if (eval_vld_r && sup_bit) begin
          n_sup_r <= n_sup_r + 1'b1;
        end
        if (eval_elig) begin
          elig_r[eval_idx_r] <= 1'b1;
          n_elig_r           <= n_elig_r + 1'b1;
        end
        if (eval_rel) begin
          rel_r[eval_idx_r] <= 1'b1;
        end
      end
      ST_DECIDE: begin
        res_r.released_mask <= rel_ext;
        if (n_sup_r == '0) begin
          res_r.none_supported <= 1'b1;
        end else begin
          res_r.all_cleared <= use_sup;
          pool_r            <= use_sup ? sup_mask_r : elig_r;
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          tgt_r      <= mod_rem;
          pick_idx_r <= '0;
          seen_r     <= '0;
        end
      end
      ST_PICK: begin
        // walk the pool one bit a cycle to the target-th set bit
        if (pick_hit) begin
          res_r.server_index <= pick_ext;
          res_r.index_valid  <= 1'b1;
        end else begin
          pick_idx_r <= pick_idx_r + 1'b1;
          if (pool_r[pick_idx_r]) begin
            seen_r <= seen_r + 1'b1;
          end
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_r <= res_r;
        end
      end
      default: ;
    endcase
  end

  assign in_if.ready           = (state_r == ST_IDLE);
  assign out_if.valid          = out_valid_r;
  assign out_if.server_index   = out_r.server_index;
  assign out_if.index_valid    = out_r.index_valid;
  assign out_if.entered_rest   = out_r.entered_rest;
  assign out_if.released_mask  = out_r.released_mask;
  assign out_if.all_cleared    = out_r.all_cleared;
  assign out_if.none_supported = out_r.none_supported;

endmodule

### hdl/fss_mod.sv
// fss_mod: iterative restoring remainder, one dividend bit per cycle
// depends on fss_pkg
module fss_mod #(
  parameter int DIV_W = 5
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  fss_pkg::fss_mod_req_t     req,
  input  logic [DIV_W-1:0]          divisor,
  output logic                      done,
  output logic [DIV_W-1:0]          rem
);
  import fss_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [RND_W-1:0]  dvd_r;
  logic [DIV_W-1:0]  rem_r;
  logic [DIV_W-1:0]  dsr_r;
  logic [DIV_W:0]    rem_sh;
  logic [DIV_W:0]    rem_sub;
  logic              last_step;

  // remainder stays below the divisor, so one subtract per step is enough
  always_comb begin
    rem_sh    = {rem_r, dvd_r[RND_W-1]};
    rem_sub   = rem_sh - {1'b0, dsr_r};
    last_step = (step_r == STEP_W'(RND_W - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && last_step;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && last_step) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      step_r <= '0;
      dvd_r  <= req.dividend;
      rem_r  <= '0;
      dsr_r  <= divisor;
    end else if (busy_r) begin
      step_r <= step_r + 1'b1;
      dvd_r  <= {dvd_r[RND_W-2:0], 1'b0};
      if (rem_sh >= {1'b0, dsr_r}) begin
        rem_r <= rem_sub[DIV_W-1:0];
      end else begin
        rem_r <= rem_sh[DIV_W-1:0];
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

### hdl/fss_checker.sv
// fss_checker: port-level checks on the failover server selector
// depends on fss_pkg; bound to failover_server_selector below
module fss_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [fss_pkg::IDX_OUT_W-1:0]   server_index,
  input logic                            index_valid,
  input logic                            entered_rest,
  input logic [fss_pkg::MASK_W-1:0]      released_mask,
  input logic                            all_cleared,
  input logic                            none_supported
);
  import fss_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(server_index)
      && $stable(released_mask) && $stable(index_valid))
    else $error("result changed while stalled");

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready after accept");

  a_none_supported: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && none_supported |-> !index_valid && (server_index == '0)
      && (released_mask == '0) && !all_cleared && !entered_rest)
    else $error("bad fields with no supporting server");

  a_entered_rest: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && entered_rest |-> index_valid && (released_mask == '0)
      && !all_cleared && !none_supported)
    else $error("bad fields on failure report");

  // a release makes a server eligible, so it never goes with a full clear
  a_all_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && all_cleared |-> index_valid && !none_supported
      && (released_mask == '0))
    else $error("bad fields on full clear");

endmodule

bind failover_server_selector fss_checker u_fss_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_if.valid),
  .in_ready       (in_if.ready),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .server_index   (out_if.server_index),
  .index_valid    (out_if.index_valid),
  .entered_rest   (out_if.entered_rest),
  .released_mask  (out_if.released_mask),
  .all_cleared    (out_if.all_cleared),
  .none_supported (out_if.none_supported)
);

### tb/fss_checker.sv
// fss_scoreboard: keeps its own copy of the selector state, predicts one result
// item per accepted request and compares it with the result channel
// depends on fss_pkg, fss_in_if and fss_out_if
module fss_scoreboard
  import fss_pkg::*;
#(
  parameter int NUM_SERVERS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  fss_in_if                     in_mon,
  fss_out_if                    out_mon,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int unsigned           errors,
  output int unsigned           outstanding
);

  // settings copy
  logic [THR_W-1:0]     rest_thr;
  logic [TIME_W-1:0]    rest_len;
  logic [TIME_W-1:0]    retry_len;
  logic [MASK_W-1:0]    chat_mask;
  logic [MASK_W-1:0]    script_mask;

  // per-server failure record and the last pick
  logic [CNT_VAL_W-1:0] strikes   [MAX_SERVERS];
  logic [TIME_W-1:0]    struck_at [MAX_SERVERS];
  logic [IDX_OUT_W-1:0] last_srv;
  logic                 last_srv_ok;

  fss_res_t             pending_outcomes [$];
  int unsigned          shown = 0;

  function automatic fss_res_t selector_outcome(input logic op, input logic kind,
                                                input logic [TIME_W-1:0] now,
                                                input logic [RND_W-1:0] rnd);
    fss_res_t          r;
    logic [MASK_W-1:0] sup;
    logic [MASK_W-1:0] elig;
    logic [MASK_W-1:0] pool;
    logic [TIME_W:0]   due;
    int unsigned       n;
    int unsigned       target;
    int unsigned       seen;
    int                i;
    r    = '0;
    sup  = '0;
    elig = '0;
    seen = 0;
    if (op == OP_FAIL) begin
      if (last_srv_ok) begin
        struck_at[last_srv] = now;
        if (strikes[last_srv] != {CNT_VAL_W{1'b1}})
          strikes[last_srv] = strikes[last_srv] + 1'b1;
        r.entered_rest = (strikes[last_srv] >= rest_thr);
        r.server_index = last_srv;
        r.index_valid  = 1'b1;
      end
    end else begin
      for (i = 0; i < NUM_SERVERS && i < MAX_SERVERS; i++) begin
        if ((kind == KIND_SCRIPTS) ? script_mask[i] : chat_mask[i]) begin
          sup[i] = 1'b1;
          if (strikes[i] >= rest_thr) begin
            due = {1'b0, struck_at[i]} + {1'b0, rest_len};
            if (due < {1'b0, now}) begin
              strikes[i]         = '0;
              r.released_mask[i] = 1'b1;
              elig[i]            = 1'b1;
            end
          end else begin
            due = {1'b0, struck_at[i]} + {1'b0, retry_len};
            if (due < {1'b0, now}) elig[i] = 1'b1;
          end
        end
      end
      if (sup == '0) begin
        r.none_supported = 1'b1;
      end else begin
        if (elig == '0) begin
          r.all_cleared = 1'b1;
          for (i = 0; i < MAX_SERVERS; i++) begin
            if (sup[i]) begin
              strikes[i]   = '0;
              struck_at[i] = '0;
            end
          end
          pool = sup;
        end else begin
          pool = elig;
        end
        n      = $countones(pool);
        target = rnd % n;
        for (i = 0; i < MAX_SERVERS; i++) begin
          if (pool[i]) begin
            if (seen == target) begin
              r.server_index = IDX_OUT_W'(i);
              break;
            end
            seen++;
          end
        end
        last_srv      = r.server_index;
        last_srv_ok   = 1'b1;
        r.index_valid = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic void note_failure(input string what, input fss_res_t want,
                                       input fss_res_t got);
    errors++;
    if (shown < 10) begin
      shown++;
      $display("%s: want idx %0d ok %0b rest %0b rel %h clr %0b none %0b",
               what, want.server_index, want.index_valid, want.entered_rest,
               want.released_mask, want.all_cleared, want.none_supported);
      $display("    got idx %0d ok %0b rest %0b rel %h clr %0b none %0b",
               got.server_index, got.index_valid, got.entered_rest,
               got.released_mask, got.all_cleared, got.none_supported);
    end
  endfunction

  always @(posedge clk) begin : watch
    fss_res_t got;
    fss_res_t want;
    fss_res_t fresh;
    int       i;
    if (!rst_n) begin
      rest_thr    = RST_REST_THR;
      rest_len    = RST_REST_TIME;
      retry_len   = RST_RETRY_TIME;
      chat_mask   = RST_TYPE_MASK;
      script_mask = RST_TYPE_MASK;
      for (i = 0; i < MAX_SERVERS; i++) begin
        strikes[i]   = '0;
        struck_at[i] = '0;
      end
      last_srv    = '0;
      last_srv_ok = 1'b0;
      pending_outcomes.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_REST_THR:   rest_thr    = cfg_wdata[THR_W-1:0];
          REG_REST_TIME:  rest_len    = cfg_wdata[TIME_W-1:0];
          REG_RETRY_TIME: retry_len   = cfg_wdata[TIME_W-1:0];
          REG_TYPE0_MASK: chat_mask   = cfg_wdata[MASK_W-1:0];
          REG_TYPE1_MASK: script_mask = cfg_wdata[MASK_W-1:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        got.server_index   = out_mon.server_index;
        got.index_valid    = out_mon.index_valid;
        got.entered_rest   = out_mon.entered_rest;
        got.released_mask  = out_mon.released_mask;
        got.all_cleared    = out_mon.all_cleared;
        got.none_supported = out_mon.none_supported;
        if (pending_outcomes.size() == 0) begin
          note_failure("result item with no request outstanding", '0, got);
        end else begin
          want = pending_outcomes.pop_front();
          if (got !== want) note_failure("result mismatch", want, got);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        fresh = selector_outcome(in_mon.opcode, in_mon.server_kind,
                                 in_mon.now_seconds, in_mon.random_value);
        pending_outcomes = {pending_outcomes, fresh};
      end
    end
    outstanding <= pending_outcomes.size();
  end

endmodule

### tb/failover_server_selector_tb.sv
// failover_server_selector_tb: clock, reset, settings and request stimulus
// for the failover server selector; checking is left to fss_scoreboard
// depends on fss_pkg, fss_in_if, fss_out_if, fss_scoreboard and the block
module failover_server_selector_tb;
  import fss_pkg::*;

  localparam logic OP_SELECT   = 1'b0;
  localparam logic KIND_CHAT   = 1'b0;
  localparam int   HOLD_CYCLES = 400;   // long receiver hold-off
  localparam int   QUIET_LIMIT = 3000;  // cycles with no handshake, settings write or reset
  localparam int   SETTLE      = 60;    // past the worst select latency

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int unsigned           errors;
  int unsigned           outstanding;
  int unsigned           quiet = 0;
  int unsigned           burst_left = 5;
  logic                  squeeze_req = 1'b0;
  logic [TIME_W-1:0]     wall = '0;      // running clock seen by the block

  fss_in_if  in_if();
  fss_out_if out_if();

  failover_server_selector u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  fss_scoreboard u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_if),
    .out_mon     (out_if),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // watchdog: any handshake, settings write or reset counts as progress
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we || !rst_n) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // result side: stretches of free flow, light and heavy stalls, and
  // one long hold-off on request so the block backs up into its input
  initial begin : result_sink
    int unsigned run_len;
    int unsigned style;
    logic        squeezed;
    squeezed = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze_req && !squeezed) begin
        squeezed = 1'b1;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      run_len = $urandom_range(10, 150);
      style   = $urandom_range(0, 3);
      repeat (run_len) begin
        case (style)
          0:       out_if.ready <= 1'b1;
          1:       out_if.ready <= 1'($urandom_range(0, 1));
          2:       out_if.ready <= ($urandom_range(0, 3) == 0);
          default: out_if.ready <= ($urandom_range(0, 7) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // one request item; valid stays up inside a burst, drops for the gap after it
  task automatic offer(input logic op, input logic kind, input logic [TIME_W-1:0] now,
                       input logic [RND_W-1:0] rnd);
    in_if.valid        <= 1'b1;
    in_if.opcode       <= op;
    in_if.server_kind  <= kind;
    in_if.now_seconds  <= now;
    in_if.random_value <= rnd;
    do @(posedge clk); while (!in_if.ready);
    if (burst_left == 0) begin
      // payload wanders while valid is low
      in_if.valid        <= 1'b0;
      in_if.opcode       <= 1'($urandom_range(0, 1));
      in_if.server_kind  <= 1'($urandom_range(0, 1));
      in_if.now_seconds  <= $urandom();
      in_if.random_value <= RND_W'($urandom_range(0, 65535));
      repeat ($urandom_range(1, 15)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 12);
    end else begin
      burst_left--;
    end
  endtask

  // stop offering and wait until every result item is back
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // all five settings, back to back, only while the block is idle
  task automatic program_regs(input logic [THR_W-1:0] thr, input logic [TIME_W-1:0] rest,
                              input logic [TIME_W-1:0] retry, input logic [MASK_W-1:0] chat,
                              input logic [MASK_W-1:0] scripts);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_REST_THR;
    cfg_wdata <= CFG_DATA_W'(thr);
    @(posedge clk);
    cfg_addr  <= REG_REST_TIME;
    cfg_wdata <= CFG_DATA_W'(rest);
    @(posedge clk);
    cfg_addr  <= REG_RETRY_TIME;
    cfg_wdata <= CFG_DATA_W'(retry);
    @(posedge clk);
    cfg_addr  <= REG_TYPE0_MASK;
    cfg_wdata <= CFG_DATA_W'(chat);
    @(posedge clk);
    cfg_addr  <= REG_TYPE1_MASK;
    cfg_wdata <= CFG_DATA_W'(scripts);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // rest and retry spans: mostly short so releases and retries happen often
  function automatic logic [TIME_W-1:0] pick_span(input int unsigned scale);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return $urandom();
      default: return $urandom_range(1, scale);
    endcase
  endfunction

  function automatic logic [MASK_W-1:0] pick_mask();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return MASK_W'(1) << $urandom_range(0, MASK_W - 1);
      default: return MASK_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // mostly a select followed by a few failure reports against that pick,
  // time moving forward; about one pass in ten is instead a noise item at any time
  task automatic run_traffic(input int unsigned count, input int unsigned step_max);
    int unsigned done;
    int unsigned fails;
    done = 0;
    while (done < count) begin
      if ($urandom_range(0, 9) == 0) begin
        offer(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom(),
              RND_W'($urandom_range(0, 65535)));
        done++;
      end else begin
        wall += $urandom_range(0, step_max);
        offer(OP_SELECT, 1'($urandom_range(0, 1)), wall, RND_W'($urandom_range(0, 65535)));
        done++;
        fails = $urandom_range(0, 4);
        repeat (fails) begin
          wall += $urandom_range(0, step_max / 4);
          offer(OP_FAIL, 1'($urandom_range(0, 1)), wall, RND_W'($urandom_range(0, 65535)));
          done++;
        end
      end
    end
  endtask

  initial begin : stimulus
    int p;
    in_if.valid        <= 1'b0;
    in_if.opcode       <= OP_SELECT;
    in_if.server_kind  <= KIND_CHAT;
    in_if.now_seconds  <= '0;
    in_if.random_value <= '0;
    cfg_we             <= 1'b0;
    cfg_addr           <= REG_REST_THR;
    cfg_wdata          <= '0;
    rst_n              <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: threshold 3, rest 600, retry 30, server 0 only
    offer(OP_FAIL, KIND_CHAT, 32'd0, 16'd0);             // nothing picked yet
    offer(OP_SELECT, KIND_CHAT, 32'd0, 16'd0);           // none eligible, clear all
    offer(OP_SELECT, KIND_SCRIPTS, 32'd0, 16'hFFFF);
    offer(OP_SELECT, KIND_CHAT, 32'd31, 16'd0);          // retry interval over
    offer(OP_FAIL, KIND_CHAT, 32'd40, 16'd0);
    offer(OP_FAIL, KIND_CHAT, 32'd41, 16'd0);
    offer(OP_FAIL, KIND_CHAT, 32'd42, 16'd0);            // reaches threshold
    offer(OP_FAIL, KIND_CHAT, 32'd43, 16'd0);
    offer(OP_SELECT, KIND_CHAT, 32'd100, 16'd0);         // still resting, clear all
    offer(OP_FAIL, KIND_CHAT, 32'd200, 16'd0);
    offer(OP_FAIL, KIND_CHAT, 32'd200, 16'd0);
    offer(OP_FAIL, KIND_CHAT, 32'd200, 16'd0);
    offer(OP_SELECT, KIND_CHAT, 32'd801, 16'd0);         // rest over, released

    // retry sum past 32 bits must not wrap; scripts has no server at all
    drain();
    program_regs(8'd2, 32'd0, 32'h20, 16'h8000, 16'h0000);
    offer(OP_SELECT, KIND_SCRIPTS, 32'd5, 16'd7);        // none supported
    offer(OP_SELECT, KIND_CHAT, 32'hFFFF_FFF0, 16'hFFFF);
    offer(OP_FAIL, KIND_CHAT, 32'hFFFF_FFF0, 16'd0);
    offer(OP_SELECT, KIND_CHAT, 32'h11, 16'd0);

    // zero threshold: every server counts as resting
    drain();
    program_regs(8'd0, 32'd0, 32'hFFFF_FFFF, 16'hFFFF, 16'hA5A5);
    offer(OP_SELECT, KIND_CHAT, 32'd0, 16'h1234);
    offer(OP_SELECT, KIND_SCRIPTS, 32'd1, 16'hFFFF);
    offer(OP_FAIL, KIND_SCRIPTS, 32'd2, 16'd0);

    // count saturation on a single server, then its release
    drain();
    program_regs(8'd255, 32'd0, 32'd0, 16'h0001, 16'h0001);
    wall = 32'd10;
    offer(OP_SELECT, KIND_CHAT, wall, RND_W'($urandom_range(0, 65535)));
    repeat (258) offer(OP_FAIL, 1'($urandom_range(0, 1)), wall,
                       RND_W'($urandom_range(0, 65535)));
    offer(OP_SELECT, KIND_SCRIPTS, wall + 32'd1, RND_W'($urandom_range(0, 65535)));

    // random traffic over a spread of settings, extremes first
    for (p = 0; p < 11; p++) begin
      drain();
      case (p)
        0:       program_regs(8'd1, 32'd0, 32'd0, 16'hFFFF, 16'h0001);
        1:       program_regs(8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, pick_mask(), 16'hFFFF);
        default: program_regs(($urandom_range(0, 7) == 0) ? THR_W'($urandom_range(0, 255))
                                                          : THR_W'($urandom_range(1, 5)),
                              pick_span(80), pick_span(20), pick_mask(), pick_mask());
      endcase
      if (p == 3) squeeze_req = 1'b1;
      run_traffic(120, 40);
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### files.f
hdl/fss_pkg.sv
hdl/fss_in_if.sv
hdl/fss_out_if.sv
hdl/fss_mod.sv
hdl/failover_server_selector.sv
hdl/fss_checker.sv
tb/fss_checker.sv
tb/failover_server_selector_tb.sv
